### src/phg_pkg.sv
// shared types, constants and codes of the point cloud height grid
`timescale 1ns / 1ps
package phg_pkg;

  localparam int POINT_DEPTH = 4096;
  localparam int PT_AW       = $clog2(POINT_DEPTH);
  localparam int PT_CW       = PT_AW + 1;
  localparam int GRID_ROWS   = 64;
  localparam int GRID_COLS   = 64;
  localparam int ROW_W       = $clog2(GRID_ROWS);
  localparam int COL_W       = $clog2(GRID_COLS);
  localparam int CELL_AW     = ROW_W + COL_W;
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 24;
  localparam int HIT_W       = 16;
  localparam int DIV_W       = 56;
  localparam int DIV_IW      = 6;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        hit_count;
    logic               unfilled;
    logic [6:0]         used_columns;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD, ST_NOP,
    ST_B_SPAN, ST_B_CS_GO, ST_B_CS_WAIT, ST_B_COL_GO, ST_B_COL_WAIT, ST_CLEAR,
    ST_P_RD, ST_P_LAT, ST_X_GO, ST_X_WAIT, ST_Y_GO, ST_Y_WAIT, ST_Z_GO, ST_Z_WAIT,
    ST_C_RD, ST_C_WR, ST_B_FIN,
    ST_R_CHK, ST_R_RD, ST_R_MUL, ST_R_GO, ST_R_WAIT, ST_R_FIN
  } state_t;

  typedef enum logic [2:0] {
    DOP_CS, DOP_COL, DOP_X, DOP_Y, DOP_Z, DOP_RD
  } div_op_t;

  typedef enum logic [1:0] {
    RSEL_PLAIN, RSEL_ADD, RSEL_READ
  } res_sel_t;

  typedef struct packed {
    logic     add_commit;
    logic     span_load;
    logic     div_start;
    logic     div_cap;
    div_op_t  div_op;
    logic     clr_en;
    logic     pt_rd;
    logic     pt_lat;
    logic     pt_next;
    logic     cell_rd;
    logic     cell_wr;
    logic     rd_mul;
    logic     built_set;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic pt_none;
    logic pt_last;
    logic read_ok;
  } sts_t;

endpackage

### src/phg_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module phg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [phg_pkg::DIV_W-1:0]    num,
  input  logic [31:0]                  den,
  input  logic [phg_pkg::DIV_IW-1:0]   iters,
  output logic                         done,
  output logic [phg_pkg::DIV_W-1:0]    quo
);
  import phg_pkg::*;

  logic [DIV_W-1:0]  nq_r;
  logic [31:0]       rem_r;
  logic [31:0]       den_r;
  logic [DIV_IW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [32:0]       trial;
  logic              qbit;
  logic [DIV_IW-1:0] shamt;

  assign shamt = DIV_IW'(DIV_W) - iters;
  assign trial = {rem_r, nq_r[DIV_W-1]} - {1'b0, den_r};
  assign qbit  = ~trial[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= iters;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_IW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num << shamt;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= qbit ? trial[31:0] : {rem_r[30:0], nq_r[DIV_W-1]};
      nq_r  <= {nq_r[DIV_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

### src/phg_datapath.sv
// point store, bounding box, cell memory and arithmetic of the height grid
`timescale 1ns / 1ps
module phg_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_item,
  input  phg_pkg::item_t       in_item,
  input  phg_pkg::cmd_t        cmd,
  output phg_pkg::sts_t        sts,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_data,
  output logic                 out_valid,
  output phg_pkg::res_t        out_res
);
  import phg_pkg::*;

  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;

  logic [95:0]              pmem [POINT_DEPTH];
  logic [SUM_W+HIT_W-1:0]   cmem [GRID_ROWS*GRID_COLS];

  item_t                  item_r;
  logic [CNT_W-1:0]       row_count_r;
  logic [PT_CW-1:0]       total_r;
  logic signed [31:0]     lo_x_r, hi_x_r, lo_y_r, hi_y_r, lo_z_r, hi_z_r;
  logic [31:0]            xr_r, yr_r, zr_r, cs_r;
  logic [CNT_W-1:0]       rows_r, cols_r;
  logic                   built_r;
  logic [PT_AW-1:0]       ptr_r;
  logic [CELL_AW-1:0]     clr_r;
  logic [95:0]            pdata_r;
  logic signed [31:0]     px_r, py_r, pz_r;
  logic [ROW_W-1:0]       ix_r;
  logic [COL_W-1:0]       iy_r;
  logic [7:0]             inten_r;
  logic [SUM_W+HIT_W-1:0] cdata_r;
  logic [DIV_W-1:0]       prod_r;
  logic [SUM_W-1:0]       hden_r;
  logic [31:0]            posx_r, posy_r, zv_r;
  res_t                   res_r;
  logic                   out_valid_r;

  logic                   full;
  logic [CNT_W-1:0]       rows_clamp;
  logic signed [32:0]     dx, dy, dz;
  logic [38:0]            nx, ny;
  logic [39:0]            nz;
  logic [DIV_W-1:0]       div_num;
  logic [31:0]            div_den;
  logic [DIV_IW-1:0]      div_iters;
  logic                   div_done;
  logic [DIV_W-1:0]       quo;
  logic [HIT_W-1:0]       c_hits;
  logic [SUM_W-1:0]       c_sum;
  logic [SUM_W+HIT_W-1:0] c_upd;
  logic [CELL_AW-1:0]     caddr;
  logic                   read_ok;
  logic signed [39:0]     sx, sy;
  res_t                   res_nxt;

  function automatic logic [31:0] span(input logic signed [31:0] lo,
                                       input logic signed [31:0] hi);
    logic signed [32:0] d;
    d = {hi[31], hi} - {lo[31], lo};
    return (d > 0) ? d[31:0] : 32'd0;
  endfunction

  function automatic logic [31:0] sat_up(input logic signed [39:0] v);
    logic [31:0] r;
    r = (v > $signed({8'd0, SMAX})) ? SMAX : v[31:0];
    return r;
  endfunction

  assign full       = (total_r == PT_CW'(POINT_DEPTH));
  assign rows_clamp = (row_count_r == '0) ? CNT_W'(1) :
                      (row_count_r > CNT_W'(GRID_ROWS)) ? CNT_W'(GRID_ROWS) : row_count_r;
  assign dx = {px_r[31], px_r} - {lo_x_r[31], lo_x_r};
  assign dy = {py_r[31], py_r} - {lo_y_r[31], lo_y_r};
  assign dz = {pz_r[31], pz_r} - {lo_z_r[31], lo_z_r};
  assign nx = 39'(dx[31:0]) * 39'(rows_r);
  assign ny = 39'(dy[31:0]) * 39'(cols_r);
  assign nz = {dz[31:0], 8'd0} - {8'd0, dz[31:0]};

  assign c_hits  = cdata_r[HIT_W-1:0];
  assign c_sum   = cdata_r[SUM_W+HIT_W-1:HIT_W];
  assign c_upd   = (c_hits == '1) ? cdata_r :
                   {c_sum + SUM_W'(inten_r), c_hits + 1'b1};
  assign caddr   = (item_r.mode == MODE_READ) ? {item_r.cell_row, item_r.cell_col}
                                              : {ix_r, iy_r};
  assign read_ok = built_r && ({1'b0, item_r.cell_row} < rows_r) &&
                   ({1'b0, item_r.cell_col} < cols_r);

  // divider operand select
  always_comb begin
    div_num   = DIV_W'(xr_r);
    div_den   = 32'(rows_r);
    div_iters = DIV_IW'(32);
    case (cmd.div_op)
      DOP_CS: begin
        div_num = DIV_W'(xr_r); div_den = 32'(rows_r); div_iters = DIV_IW'(32);
      end
      DOP_COL: begin
        div_num = DIV_W'(yr_r); div_den = cs_r; div_iters = DIV_IW'(32);
      end
      DOP_X: begin
        div_num = DIV_W'(nx); div_den = xr_r; div_iters = DIV_IW'(39);
      end
      DOP_Y: begin
        div_num = DIV_W'(ny); div_den = yr_r; div_iters = DIV_IW'(39);
      end
      DOP_Z: begin
        div_num = DIV_W'(nz); div_den = zr_r; div_iters = DIV_IW'(40);
      end
      DOP_RD: begin
        div_num = prod_r; div_den = 32'(hden_r); div_iters = DIV_IW'(DIV_W);
      end
      default: ;
    endcase
  end

  phg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quo   (quo)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(64);
      total_r     <= '0;
      lo_x_r      <= 32'sh7FFF_FFFF;
      lo_y_r      <= 32'sh7FFF_FFFF;
      lo_z_r      <= 32'sh7FFF_FFFF;
      hi_x_r      <= 32'sh8000_0000;
      hi_y_r      <= 32'sh8000_0000;
      hi_z_r      <= 32'sh8000_0000;
      cs_r        <= '0;
      cols_r      <= '0;
      rows_r      <= '0;
      built_r     <= 1'b0;
      ptr_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_load;
      if (cfg_we) row_count_r <= cfg_data;
      if (cmd.add_commit && !full) begin
        total_r <= total_r + 1'b1;
        if (item_r.coord_x < lo_x_r) lo_x_r <= item_r.coord_x;
        if (item_r.coord_x > hi_x_r) hi_x_r <= item_r.coord_x;
        if (item_r.coord_y < lo_y_r) lo_y_r <= item_r.coord_y;
        if (item_r.coord_y > hi_y_r) hi_y_r <= item_r.coord_y;
        if (item_r.coord_z < lo_z_r) lo_z_r <= item_r.coord_z;
        if (item_r.coord_z > hi_z_r) hi_z_r <= item_r.coord_z;
        built_r <= 1'b0;
      end
      if (cmd.span_load) begin
        rows_r <= rows_clamp;
        ptr_r  <= '0;
        clr_r  <= '0;
      end
      if (cmd.div_cap && cmd.div_op == DOP_CS) cs_r <= quo[31:0];
      if (cmd.div_cap && cmd.div_op == DOP_COL) begin
        if (cs_r == '0 || quo == '0)         cols_r <= CNT_W'(1);
        else if (quo > DIV_W'(GRID_COLS))     cols_r <= CNT_W'(GRID_COLS);
        else                                  cols_r <= quo[CNT_W-1:0];
      end
      if (cmd.clr_en)    clr_r   <= clr_r + 1'b1;
      if (cmd.pt_next)   ptr_r   <= ptr_r + 1'b1;
      if (cmd.built_set) built_r <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_item) item_r <= in_item;
    if (cmd.span_load) begin
      xr_r <= span(lo_x_r, hi_x_r);
      yr_r <= span(lo_y_r, hi_y_r);
      zr_r <= span(lo_z_r, hi_z_r);
    end
    if (cmd.pt_lat) begin
      px_r <= pdata_r[95:64];
      py_r <= pdata_r[63:32];
      pz_r <= pdata_r[31:0];
    end
    if (cmd.div_cap) begin
      case (cmd.div_op)
        DOP_X: begin
          if (xr_r == '0 || dx <= 0)              ix_r <= '0;
          else if (quo >= DIV_W'(rows_r))         ix_r <= ROW_W'(rows_r - 1'b1);
          else                                    ix_r <= quo[ROW_W-1:0];
        end
        DOP_Y: begin
          if (yr_r == '0 || dy <= 0)              iy_r <= '0;
          else if (quo >= DIV_W'(cols_r))         iy_r <= COL_W'(cols_r - 1'b1);
          else                                    iy_r <= quo[COL_W-1:0];
        end
        DOP_Z: begin
          if (zr_r == '0 || dz <= 0)              inten_r <= '0;
          else if (quo > DIV_W'(255))             inten_r <= 8'hFF;
          else                                    inten_r <= quo[7:0];
        end
        DOP_RD: begin
          if (c_hits == '0)                       zv_r <= '0;
          else if (quo > DIV_W'(SMAX))            zv_r <= SMAX;
          else                                    zv_r <= quo[31:0];
        end
        default: ;
      endcase
    end
    if (cmd.rd_mul) begin
      prod_r <= DIV_W'(c_sum) * DIV_W'(zr_r);
      hden_r <= {c_hits, 8'd0} - {8'd0, c_hits};
      posx_r <= sat_up(sx);
      posy_r <= sat_up(sy);
    end
  end

  assign sx = 40'(lo_x_r) + $signed({2'b00, 38'(item_r.cell_row) * 38'(cs_r)});
  assign sy = 40'(lo_y_r) + $signed({2'b00, 38'(item_r.cell_col) * 38'(cs_r)});

  // point store
  always_ff @(posedge clk) begin
    if (cmd.add_commit && !full)
      pmem[total_r[PT_AW-1:0]] <= {item_r.coord_x, item_r.coord_y, item_r.coord_z};
    if (cmd.pt_rd) pdata_r <= pmem[ptr_r];
  end

  // cell memory: sum and hit count, empty means no hits
  always_ff @(posedge clk) begin
    if (cmd.clr_en)       cmem[clr_r]      <= '0;
    else if (cmd.cell_wr) cmem[{ix_r, iy_r}] <= c_upd;
    if (cmd.cell_rd) cdata_r <= cmem[caddr];
  end

  // result beat contents
  always_comb begin
    res_nxt              = '0;
    res_nxt.used_columns = cols_r;
    case (cmd.res_sel)
      RSEL_ADD:  res_nxt.status = full ? STATUS_FULL : STATUS_OK;
      RSEL_READ: begin
        if (!read_ok) begin
          res_nxt.status = STATUS_BAD;
        end else begin
          res_nxt.status    = STATUS_OK;
          res_nxt.out_x     = posx_r;
          res_nxt.out_y     = posy_r;
          res_nxt.out_z     = zv_r;
          res_nxt.hit_count = c_hits;
          res_nxt.unfilled  = (c_hits == '0);
        end
      end
      default:   res_nxt.status = STATUS_OK;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) res_r <= res_nxt;
  end

  assign sts.div_done = div_done;
  assign sts.clr_last = (clr_r == '1);
  assign sts.pt_none  = (total_r == '0);
  assign sts.pt_last  = ((PT_CW'(ptr_r) + 1'b1) == total_r);
  assign sts.read_ok  = read_ok;
  assign out_valid    = out_valid_r;
  assign out_res      = res_r;

endmodule

### src/phg_ctrl.sv
// sequencer of the height grid: add, build pass and cell read
`timescale 1ns / 1ps
module phg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     mode,
  input  phg_pkg::sts_t  sts,
  output logic           busy,
  output logic           load_item,
  output phg_pkg::cmd_t  cmd
);
  import phg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_ADD:   state_nxt = ST_ADD;
            MODE_BUILD: state_nxt = ST_B_SPAN;
            MODE_READ:  state_nxt = ST_R_CHK;
            default:    state_nxt = ST_NOP;
          endcase
        end
      end
      ST_ADD, ST_NOP, ST_B_FIN, ST_R_FIN: state_nxt = ST_IDLE;
      ST_B_SPAN:     state_nxt = ST_B_CS_GO;
      ST_B_CS_GO:    state_nxt = ST_B_CS_WAIT;
      ST_B_CS_WAIT:  if (sts.div_done) state_nxt = ST_B_COL_GO;
      ST_B_COL_GO:   state_nxt = ST_B_COL_WAIT;
      ST_B_COL_WAIT: if (sts.div_done) state_nxt = ST_CLEAR;
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = sts.pt_none ? ST_B_FIN : ST_P_RD;
      end
      ST_P_RD:       state_nxt = ST_P_LAT;
      ST_P_LAT:      state_nxt = ST_X_GO;
      ST_X_GO:       state_nxt = ST_X_WAIT;
      ST_X_WAIT:     if (sts.div_done) state_nxt = ST_Y_GO;
      ST_Y_GO:       state_nxt = ST_Y_WAIT;
      ST_Y_WAIT:     if (sts.div_done) state_nxt = ST_Z_GO;
      ST_Z_GO:       state_nxt = ST_Z_WAIT;
      ST_Z_WAIT:     if (sts.div_done) state_nxt = ST_C_RD;
      ST_C_RD:       state_nxt = ST_C_WR;
      ST_C_WR:       state_nxt = sts.pt_last ? ST_B_FIN : ST_P_RD;
      ST_R_CHK:      state_nxt = sts.read_ok ? ST_R_RD : ST_R_FIN;
      ST_R_RD:       state_nxt = ST_R_MUL;
      ST_R_MUL:      state_nxt = ST_R_GO;
      ST_R_GO:       state_nxt = ST_R_WAIT;
      ST_R_WAIT:     if (sts.div_done) state_nxt = ST_R_FIN;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.div_op  = DOP_CS;
    cmd.res_sel = RSEL_PLAIN;
    busy      = (state_r != ST_IDLE);
    load_item = (state_r == ST_IDLE) && start;
    case (state_r)
      ST_ADD: begin
        cmd.add_commit = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RSEL_ADD;
      end
      ST_NOP:        cmd.res_load = 1'b1;
      ST_B_SPAN:     cmd.span_load = 1'b1;
      ST_B_CS_GO:    begin cmd.div_start = 1'b1; cmd.div_op = DOP_CS; end
      ST_B_CS_WAIT:  begin cmd.div_cap = sts.div_done; cmd.div_op = DOP_CS; end
      ST_B_COL_GO:   begin cmd.div_start = 1'b1; cmd.div_op = DOP_COL; end
      ST_B_COL_WAIT: begin cmd.div_cap = sts.div_done; cmd.div_op = DOP_COL; end
      ST_CLEAR:      cmd.clr_en = 1'b1;
      ST_P_RD:       cmd.pt_rd = 1'b1;
      ST_P_LAT:      cmd.pt_lat = 1'b1;
      ST_X_GO:       begin cmd.div_start = 1'b1; cmd.div_op = DOP_X; end
      ST_X_WAIT:     begin cmd.div_cap = sts.div_done; cmd.div_op = DOP_X; end
      ST_Y_GO:       begin cmd.div_start = 1'b1; cmd.div_op = DOP_Y; end
      ST_Y_WAIT:     begin cmd.div_cap = sts.div_done; cmd.div_op = DOP_Y; end
      ST_Z_GO:       begin cmd.div_start = 1'b1; cmd.div_op = DOP_Z; end
      ST_Z_WAIT:     begin cmd.div_cap = sts.div_done; cmd.div_op = DOP_Z; end
      ST_C_RD:       cmd.cell_rd = 1'b1;
      ST_C_WR:       begin cmd.cell_wr = 1'b1; cmd.pt_next = 1'b1; end
      ST_B_FIN:      begin cmd.built_set = 1'b1; cmd.res_load = 1'b1; end
      ST_R_RD:       cmd.cell_rd = 1'b1;
      ST_R_MUL:      cmd.rd_mul = 1'b1;
      ST_R_GO:       begin cmd.div_start = 1'b1; cmd.div_op = DOP_RD; end
      ST_R_WAIT:     begin cmd.div_cap = sts.div_done; cmd.div_op = DOP_RD; end
      ST_R_FIN:      begin cmd.res_load = 1'b1; cmd.res_sel = RSEL_READ; end
      default: ;
    endcase
  end

endmodule

### src/point_cloud_height_grid.sv
// top level of the point cloud height grid
`timescale 1ns / 1ps
// usage
//   input beat: in_item is taken at a rising edge with start high and busy low.
//   mode add stores one Q24.8 point and widens the bounding box unless the
//   point store is full, mode build rasterizes every stored point into the
//   grid, mode read returns one cell, mode three does nothing but answer.
//   every beat gives exactly one result beat: out_valid is high for one cycle
//   with out_res; the receiver cannot stall and must take it then.
//   cfg_we writes cfg_data to the row count; write it only while idle.
// sequence, from the accept to the result
//   add and no-op: the add or no-op state loads the result register, and
//   a new beat is taken only once that result is shown
//   read: cell check, cell read, multiply, then the 56-bit serial divider
//   for the height; a read outside the built grid skips all but the check
//   build: a sweep clearing all 4096 cells, then per stored point a point
//   read, three serial divisions and a read-modify-write of the cell memory
//   busy is high from the accept until the cycle the result is shown.
// reset
//   rst_n is synchronous, active low: empty point store, sentinel bounding
//   box, grid not built, row count 64.
module point_cloud_height_grid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  phg_pkg::item_t  in_item,
  output logic            out_valid,
  output phg_pkg::res_t   out_res,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data
);
  import phg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic load_item;

  // sequencer
  phg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode      (in_item.mode),
    .sts       (sts),
    .busy      (busy),
    .load_item (load_item),
    .cmd       (cmd)
  );

  // storage and arithmetic
  phg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_item (load_item),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // a result beat is never followed directly by another
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result beats");

  // an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // an add answers once its ADD state has loaded the result register
  a_add_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == MODE_ADD) |=> ##1 out_valid)
    else $error("add result missing");

  // results carry a defined status and the block is idle when they show
  a_result_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && (out_res.status == STATUS_OK ||
                             out_res.status == STATUS_FULL ||
                             out_res.status == STATUS_BAD)))
    else $error("bad result status");

endmodule

### sim/testbench.sv
// self-checking testbench for the point cloud height grid top level
`timescale 1ns / 1ps
module testbench;
  import phg_pkg::*;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  item_t in_item;
  logic  out_valid;
  res_t  out_res;
  logic  cfg_we;
  logic  [6:0] cfg_data;

  point_cloud_height_grid dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow copy of the grid state, updated at each accepted beat
  logic signed [31:0] pt_x [POINT_DEPTH];
  logic signed [31:0] pt_y [POINT_DEPTH];
  logic signed [31:0] pt_z [POINT_DEPTH];
  int                 pt_total;
  int                 lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  longint unsigned    cell_sz;
  int                 col_total;
  int                 row_total;
  longint unsigned    sum_of_cell [GRID_ROWS*GRID_COLS];
  int                 hits_of_cell [GRID_ROWS*GRID_COLS];
  bit                 cell_vacant [GRID_ROWS*GRID_COLS];
  bit                 grid_ready;
  int                 row_setting;

  res_t pending_cells [$];
  int   fail_cnt;
  int   n_beats, n_adds, n_builds, n_reads, n_full, n_bad, n_cfg;
  int   burst_left;

  function automatic longint unsigned extent(int lo, int hi);
    longint d;
    d = longint'(hi) - longint'(lo);
    return d > 0 ? longint'(d) : 0;
  endfunction

  function automatic int bin_of(int v, int lo, longint unsigned rng, int n);
    longint d;
    longint unsigned idx;
    d = longint'(v) - longint'(lo);
    if (rng == 0 || d <= 0) return 0;
    idx = (longint'(d) * n) / rng;
    return idx >= n ? n - 1 : int'(idx);
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // rasterize every stored point into the shadow grid
  task automatic rasterize();
    int rows, i, j, c;
    longint unsigned xr, yr, zr, cols, inten;
    longint dz;
    rows = row_setting;
    if (rows < 1) rows = 1;
    if (rows > GRID_ROWS) rows = GRID_ROWS;
    xr = extent(lo_x, hi_x);
    yr = extent(lo_y, hi_y);
    zr = extent(lo_z, hi_z);
    cell_sz = (xr / rows) & 64'hFFFF_FFFF;
    cols = cell_sz != 0 ? yr / cell_sz : 1;
    if (cols < 1) cols = 1;
    if (cols > GRID_COLS) cols = GRID_COLS;
    col_total = int'(cols);
    row_total = rows;
    for (int k = 0; k < GRID_ROWS*GRID_COLS; k++) begin
      sum_of_cell[k] = 0;
      hits_of_cell[k] = 0;
      cell_vacant[k] = 1'b1;
    end
    for (int p = 0; p < pt_total; p++) begin
      i = bin_of(pt_x[p], lo_x, xr, rows);
      j = bin_of(pt_y[p], lo_y, yr, col_total);
      c = i * GRID_COLS + j;
      inten = 0;
      dz = longint'(pt_z[p]) - longint'(lo_z);
      if (zr != 0 && dz > 0) inten = (255 * longint'(dz)) / zr;
      if (inten > 255) inten = 255;
      // sum freezes once the hit count saturates
      if (hits_of_cell[c] < 65535) begin
        hits_of_cell[c]++;
        sum_of_cell[c] += inten;
      end
      cell_vacant[c] = 1'b0;
    end
    grid_ready = 1'b1;
  endtask

  // expected result beat for one accepted input beat
  task automatic grid_response(input item_t it, output res_t r);
    int ri, ci, k;
    longint unsigned zr, zv;
    r = '0;
    case (it.mode)
      MODE_ADD: begin
        if (pt_total >= POINT_DEPTH) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          pt_x[pt_total] = it.coord_x;
          pt_y[pt_total] = it.coord_y;
          pt_z[pt_total] = it.coord_z;
          pt_total++;
          if (it.coord_x < lo_x) lo_x = it.coord_x;
          if (it.coord_x > hi_x) hi_x = it.coord_x;
          if (it.coord_y < lo_y) lo_y = it.coord_y;
          if (it.coord_y > hi_y) hi_y = it.coord_y;
          if (it.coord_z < lo_z) lo_z = it.coord_z;
          if (it.coord_z > hi_z) hi_z = it.coord_z;
          grid_ready = 1'b0;
        end
        n_adds++;
      end
      MODE_BUILD: begin
        rasterize();
        n_builds++;
      end
      MODE_READ: begin
        ri = int'(it.cell_row);
        ci = int'(it.cell_col);
        n_reads++;
        if (!grid_ready || ri >= row_total || ci >= col_total) begin
          r.status = STATUS_BAD;
          n_bad++;
        end else begin
          k = ri * GRID_COLS + ci;
          zr = extent(lo_z, hi_z);
          zv = 0;
          if (hits_of_cell[k] != 0)
            zv = (sum_of_cell[k] * zr) / (longint'(hits_of_cell[k]) * 255);
          r.out_x = clip32(longint'(lo_x) + longint'(ri) * longint'(cell_sz));
          r.out_y = clip32(longint'(lo_y) + longint'(ci) * longint'(cell_sz));
          r.out_z = clip32(longint'(zv));
          r.hit_count = hits_of_cell[k][15:0];
          r.unfilled = cell_vacant[k];
        end
      end
      default: ;
    endcase
    r.used_columns = col_total[6:0];
  endtask

  // compare every result beat against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid) begin
      if (pending_cells.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        want = pending_cells.pop_front();
        if (out_res.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_res.status);
          fail_cnt++;
        end
        if (out_res.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, out_res.out_x);
          fail_cnt++;
        end
        if (out_res.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, out_res.out_y);
          fail_cnt++;
        end
        if (out_res.out_z !== want.out_z) begin
          $error("out_z expected %0d actual %0d", want.out_z, out_res.out_z);
          fail_cnt++;
        end
        if (out_res.hit_count !== want.hit_count) begin
          $error("hit_count expected %0d actual %0d", want.hit_count, out_res.hit_count);
          fail_cnt++;
        end
        if (out_res.unfilled !== want.unfilled) begin
          $error("unfilled expected %0d actual %0d", want.unfilled, out_res.unfilled);
          fail_cnt++;
        end
        if (out_res.used_columns !== want.used_columns) begin
          $error("used_columns expected %0d actual %0d", want.used_columns,
                 out_res.used_columns);
          fail_cnt++;
        end
      end
    end
  end

  // one input beat; bursts of random length with random gaps between them
  task automatic send_beat(input item_t it);
    res_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    grid_response(it, r);
    pending_cells.insert(pending_cells.size(), r);
    n_beats++;
    burst_left--;
  endtask

  function automatic item_t point_beat(int x, int y, int z);
    item_t it;
    it = '0;
    it.mode = MODE_ADD;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.cell_row = 6'($urandom);
    it.cell_col = 6'($urandom);
    return it;
  endfunction

  function automatic item_t cmd_beat(logic [1:0] m, int ri, int ci);
    item_t it;
    it = '0;
    it.mode = m;
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    it.coord_z = $urandom;
    it.cell_row = 6'(ri);
    it.cell_col = 6'(ci);
    return it;
  endfunction

  // drain all results, then write the row count while the block is idle
  task automatic set_rows(input logic [6:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    row_setting = int'(v);
    n_cfg++;
  endtask

  // reads mostly inside the built grid, some anywhere
  task automatic read_some(input int n);
    int ri, ci;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0 && row_total > 0 && col_total > 0) begin
        ri = $urandom_range(0, row_total - 1);
        ci = $urandom_range(0, col_total - 1);
      end else begin
        ri = $urandom_range(0, 63);
        ci = $urandom_range(0, 63);
      end
      send_beat(cmd_beat(MODE_READ, ri, ci));
    end
  endtask

  // reads before any build, a build of nothing, no-op, flat z
  task automatic test_empty_grid();
    send_beat(cmd_beat(MODE_READ, 0, 0));
    send_beat(cmd_beat(MODE_NOP, 0, 0));
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    send_beat(cmd_beat(MODE_READ, 0, 0));
    send_beat(cmd_beat(MODE_READ, 63, 63));
    send_beat(point_beat(256, 512, 1000));
    send_beat(point_beat(256, 512, 1000));
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    send_beat(cmd_beat(MODE_READ, 0, 0));
  endtask

  // row count at both extremes of the register, with edge points
  task automatic test_row_extremes();
    set_rows(7'd0);
    send_beat(point_beat(-25600, -12800, -5000));
    send_beat(point_beat(25600, 40000, 5000));
    send_beat(point_beat(0, 0, 0));
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    send_beat(cmd_beat(MODE_READ, 0, 0));
    send_beat(cmd_beat(MODE_READ, 1, 0));
    set_rows(7'd127);
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    send_beat(cmd_beat(MODE_READ, 63, 0));
    send_beat(cmd_beat(MODE_READ, 0, 63));
    send_beat(cmd_beat(MODE_READ, 0, 0));
  endtask

  // an add after a build invalidates the grid until the next build
  task automatic test_add_after_build();
    set_rows(7'd64);
    send_beat(point_beat(100, 100, 100));
    send_beat(cmd_beat(MODE_READ, 0, 0));
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    send_beat(cmd_beat(MODE_READ, 0, 0));
  endtask

  // rounds of points, a build and reads; the row count moves between rounds
  task automatic test_random_rounds();
    int k, base_x, base_y, base_z, spread_sz, style;
    while (n_beats < 1000) begin
      if ($urandom_range(0, 1) == 0) set_rows(7'($urandom_range(0, 3) == 0 ?
                                                $urandom : $urandom_range(1, 64)));
      k = $urandom_range(0, 16);
      style = $urandom_range(0, 5);
      base_x = $urandom_range(0, 1 << 22) - (1 << 21);
      base_y = $urandom_range(0, 1 << 22) - (1 << 21);
      base_z = $urandom_range(0, 1 << 22) - (1 << 21);
      spread_sz = 1 << $urandom_range(4, 20);
      for (int i = 0; i < k; i++) begin
        if (style == 0)
          send_beat(point_beat($urandom, $urandom, $urandom));
        else
          send_beat(point_beat(base_x + $urandom_range(0, spread_sz),
                               base_y + $urandom_range(0, spread_sz),
                               base_z + $urandom_range(0, spread_sz)));
      end
      send_beat(cmd_beat(MODE_BUILD, 0, 0));
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 29))
          0: send_beat(cmd_beat(MODE_NOP, $urandom, $urandom));
          1: send_beat(point_beat(base_x, base_y, base_z));
          2: send_beat(cmd_beat(MODE_BUILD, 0, 0));
          default: read_some(1);
        endcase
      end
    end
  endtask

  // most extreme coordinates, a build, two corner reads, then a rebuild with 64 rows and random reads
  task automatic test_wide_coords();
    set_rows(7'd1);
    send_beat(point_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_beat(point_beat(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    send_beat(cmd_beat(MODE_READ, 0, 0));
    send_beat(cmd_beat(MODE_READ, 0, 63));
    set_rows(7'd64);
    send_beat(cmd_beat(MODE_BUILD, 0, 0));
    read_some(12);
  endtask

  // overall limit on run time
  initial begin
    #(64'd12 * 64'd30_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    pt_total = 0;
    lo_x = 32'sh7fff_ffff; lo_y = 32'sh7fff_ffff; lo_z = 32'sh7fff_ffff;
    hi_x = 32'sh8000_0000; hi_y = 32'sh8000_0000; hi_z = 32'sh8000_0000;
    cell_sz = 0; col_total = 0; row_total = 0;
    for (int k = 0; k < GRID_ROWS*GRID_COLS; k++) begin
      sum_of_cell[k] = 0;
      hits_of_cell[k] = 0;
      cell_vacant[k] = 1'b1;
    end
    grid_ready = 1'b0;
    row_setting = 64;
    fail_cnt = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_grid();
    test_row_extremes();
    test_add_after_build();
    test_random_rounds();
    test_wide_coords();

    @(negedge clk);
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d beats: %0d adds (%0d full), %0d builds, %0d reads (%0d rejected)",
             n_beats, n_adds, n_full, n_builds, n_reads, n_bad);
    $display("row count written %0d times, %0d points stored", n_cfg, pt_total);
    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
